// ===== src/assert_macros.svh =====
// Assertion macros shared by the tone generator RTL.
// Both macros compile to nothing when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== src/tsg_pkg.sv =====
// Shared types and constants for the wavetable / square tone generator.
// No dependencies.
package tsg_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int PHASE_FRAC_DEFAULT  = 16;
   localparam int QUEUE_DEPTH         = 4;

   localparam int ACC_W    = 24;
   localparam int SAMPLE_W = 16;
   localparam int HALF_W   = 16;
   localparam int AMP_W    = 15;
   localparam int INDEX_W  = 8;
   localparam int REQ_W    = 2;
   localparam int CSR_AW   = 1;

   localparam logic [AMP_W-1:0] AMP_RESET = 15'd1000;

   // request codes carried in req_tuser
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_WAVE_MODE  = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_SQUARE_AMP = 1'b1;

   // per-entry control handed from front to back
   typedef struct packed {
      logic is_load;    // table write, no result
      logic use_table;  // sample comes from the wave table
      logic hold_last;  // idle tick: repeat last sample, muted
      logic tone_last;  // final sample of the tone
   } q_ctl_type;

endpackage

// ===== src/wavetable_square_tone_generator.sv =====
// Wavetable / square tone generator, top level.
// Depends on tsg_pkg, tsg_front, tsg_queue and tsg_back.
//
// Requests arrive on the req_ stream; req_tuser holds the request code (load
// table entry, start tone, sample tick). Loads write one wave table entry,
// starts arm a tone, and every tick gives exactly one sample on the rsp_
// stream: rsp_tdata is the signed sample, rsp_tuser is the muted flag of an
// idle tick and rsp_tlast marks the final sample of a tone. Loads and starts
// give no result. The csr_ port writes wave_mode or square_amplitude, one
// register per write; write it only while no tick is in flight.
// Throughput is one request per cycle while req_tready is high. A tick's sample
// passes the request queue, the registered wave table read and the result
// register before it appears on rsp_tvalid. When the receiver stalls, the result
// register holds, the table stage and the four-entry queue fill, and then
// req_tready drops; the front keeps the tone state, so nothing is lost or
// repeated.
// Synchronous reset clears the tone state (tone idle, level zero, last sample
// zero) and the registers to sine mode with amplitude 1000. The wave table is
// not cleared: load an entry before a tone reads it.
// The user must keep TABLE_DEPTH a power of two; the block does not enforce it.
module wavetable_square_tone_generator #(
   parameter int TABLE_DEPTH     = tsg_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PHASE_FRAC_BITS = tsg_pkg::PHASE_FRAC_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // table_index, table_value, phase_step, half_period, tone_samples
   input  logic [87:0]                   req_tdata,
   // req_type
   input  logic [tsg_pkg::REQ_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // sample_out
   output logic [tsg_pkg::SAMPLE_W-1:0]  rsp_tdata,
   // muted
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [tsg_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [tsg_pkg::AMP_W-1:0]     csr_wdata
);
   localparam int TABLE_AW = $clog2(TABLE_DEPTH);
   localparam int CTL_W    = $bits(tsg_pkg::q_ctl_type);
   localparam int Q_W      = CTL_W + tsg_pkg::SAMPLE_W + TABLE_AW;

   logic                          push, pop, q_full, q_valid;
   tsg_pkg::q_ctl_type            push_ctl, q_ctl;
   logic [tsg_pkg::SAMPLE_W-1:0]  push_data, q_data;
   logic [TABLE_AW-1:0]           push_addr, q_addr;
   logic [Q_W-1:0]                q_wdata, q_rdata;

   assign req_tready = !q_full;
   assign q_wdata    = {push_addr, push_data, push_ctl};
   assign {q_addr, q_data, q_ctl} = q_rdata;

   tsg_front #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
      .TABLE_AW        (TABLE_AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_data  (push_data),
      .push_addr  (push_addr)
   );

   tsg_queue #(
      .WIDTH (Q_W),
      .DEPTH (tsg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wdata   (q_wdata),
      .full    (q_full),
      .pop     (pop),
      .q_valid (q_valid),
      .rdata   (q_rdata)
   );

   tsg_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TABLE_AW    (TABLE_AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ctl      (q_ctl),
      .q_data     (q_data),
      .q_addr     (q_addr),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/tsg_queue.sv =====
// Small register FIFO between the front and back of the tone generator.
// Depends on tsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tsg_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = tsg_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output logic [WIDTH-1:0] rdata
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_NEVER(a_q_overflow, clock, reset, push && full && !pop, "queue push while full")
   `ASSERT_NEVER(a_q_underflow, clock, reset, pop && !q_valid, "queue pop while empty")

endmodule

// ===== src/tsg_front.sv =====
// Front of the tone generator: takes requests and configuration, keeps the
// tone state (phase, half-period counter, length) and queues loads and ticks.
// Depends on tsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tsg_front #(
   parameter int TABLE_DEPTH     = tsg_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PHASE_FRAC_BITS = tsg_pkg::PHASE_FRAC_DEFAULT,
   parameter int TABLE_AW        = $clog2(TABLE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [87:0]                       req_tdata,
   input  logic [tsg_pkg::REQ_W-1:0]         req_tuser,
   input  logic                              csr_we,
   input  logic [tsg_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [tsg_pkg::AMP_W-1:0]         csr_wdata,
   output logic                              push,
   output tsg_pkg::q_ctl_type                push_ctl,
   output logic [tsg_pkg::SAMPLE_W-1:0]      push_data,
   output logic [TABLE_AW-1:0]               push_addr
);
   localparam int ACC_W = tsg_pkg::ACC_W;
   localparam int HW    = tsg_pkg::HALF_W;

   logic                          in_acc;
   logic [tsg_pkg::INDEX_W-1:0]   f_index;
   logic [tsg_pkg::SAMPLE_W-1:0]  f_value;
   logic [ACC_W-1:0]              f_step;
   logic [HW-1:0]                 f_half;
   logic [ACC_W-1:0]              f_samples;

   logic                          wave_mode_ff, wave_mode_in;
   logic [tsg_pkg::AMP_W-1:0]     amp_ff, amp_in;
   logic [ACC_W-1:0]              phase_ff, phase_in;
   logic [ACC_W-1:0]              step_ff, step_in;
   logic [ACC_W-1:0]              left_ff, left_in;
   logic [HW-1:0]                 half_len_ff, half_len_in;
   logic [HW-1:0]                 half_cnt_ff, half_cnt_in;
   logic [tsg_pkg::SAMPLE_W-1:0]  level_ff, level_in;

   logic [ACC_W-1:0]              phase_shift;
   logic [ACC_W+TABLE_AW-1:0]     phase_wide;
   logic [31:0]                   index_wide;
   logic [HW:0]                   half_inc;
   logic                          active;

   assign in_acc    = req_tvalid && req_tready;
   assign f_index   = req_tdata[7:0];
   assign f_value   = req_tdata[23:8];
   assign f_step    = req_tdata[47:24];
   assign f_half    = req_tdata[63:48];
   assign f_samples = req_tdata[87:64];

   assign active      = (left_ff != '0);
   assign phase_shift = phase_ff >> PHASE_FRAC_BITS;
   assign phase_wide  = (ACC_W + TABLE_AW)'(phase_shift);
   assign index_wide  = 32'(f_index);
   assign half_inc    = {1'b0, half_cnt_ff} + (HW + 1)'(1);

   always_comb begin
      wave_mode_in = wave_mode_ff;
      amp_in       = amp_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tsg_pkg::CSR_WAVE_MODE:  wave_mode_in = csr_wdata[0];
            tsg_pkg::CSR_SQUARE_AMP: amp_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      left_in     = left_ff;
      half_len_in = half_len_ff;
      half_cnt_in = half_cnt_ff;
      level_in    = level_ff;
      push        = 1'b0;
      push_ctl    = '0;
      push_data   = '0;
      push_addr   = '0;
      if (in_acc) begin
         unique case (req_tuser)
            tsg_pkg::REQ_LOAD: begin
               push             = 1'b1;
               push_ctl.is_load = 1'b1;
               push_data        = f_value;
               push_addr        = index_wide[TABLE_AW-1:0];
            end
            tsg_pkg::REQ_START: begin
               step_in     = f_step;
               half_len_in = (f_half == '0) ? HW'(1) : f_half;
               left_in     = f_samples;
               phase_in    = '0;
               half_cnt_in = '0;
               level_in    = {1'b0, amp_ff};
            end
            tsg_pkg::REQ_TICK: begin
               push = 1'b1;
               if (!active) begin
                  push_ctl.hold_last = 1'b1;
               end else begin
                  // invert at the start of each half period
                  if (half_cnt_ff == '0) begin
                     level_in = tsg_pkg::SAMPLE_W'(~level_ff + 1'b1);
                  end else begin
                     level_in = level_ff;
                  end
                  half_cnt_in = (half_inc >= {1'b0, half_len_ff}) ? '0 : half_inc[HW-1:0];
                  phase_in    = ACC_W'(phase_ff + step_ff);
                  left_in     = ACC_W'(left_ff - 1'b1);
                  push_ctl.use_table = !wave_mode_ff;
                  push_ctl.tone_last = (left_ff == ACC_W'(1));
                  push_data          = level_in;
                  push_addr          = phase_wide[TABLE_AW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff <= 1'b0;
         amp_ff       <= tsg_pkg::AMP_RESET;
         phase_ff     <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         half_len_ff  <= HW'(1);
         half_cnt_ff  <= '0;
         level_ff     <= '0;
      end else begin
         wave_mode_ff <= wave_mode_in;
         amp_ff       <= amp_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         half_len_ff  <= half_len_in;
         half_cnt_ff  <= half_cnt_in;
         level_ff     <= level_in;
      end
   end

   `ASSERT_NEVER(a_half_cnt_range, clock, reset, half_cnt_ff >= half_len_ff,
      "half-period counter reached its limit")
   `ASSERT_SYNC(a_left_count, clock, reset,
      in_acc && (req_tuser == tsg_pkg::REQ_TICK) && active |=> left_ff == $past(left_ff) - 1'b1,
      "tone length did not count down on an active tick")

endmodule

// ===== src/tsg_back.sv =====
// Back of the tone generator: drains the queue, writes and reads the wave
// table, picks the sample and holds it in the result register.
// Depends on tsg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tsg_back #(
   parameter int TABLE_DEPTH = tsg_pkg::TABLE_DEPTH_DEFAULT,
   parameter int TABLE_AW    = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tsg_pkg::q_ctl_type            q_ctl,
   input  logic [tsg_pkg::SAMPLE_W-1:0]  q_data,
   input  logic [TABLE_AW-1:0]           q_addr,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tsg_pkg::SAMPLE_W-1:0]  rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);
   localparam int SW = tsg_pkg::SAMPLE_W;

   logic [SW-1:0]       wave_mem [TABLE_DEPTH];
   logic [SW-1:0]       rd_ff;

   logic                a_valid_ff, a_valid_in;
   tsg_pkg::q_ctl_type  a_ctl_ff;
   logic [SW-1:0]       a_sq_ff;
   logic                a_adv;

   logic                out_valid_ff, out_valid_in;
   logic [SW-1:0]       out_sample_ff;
   logic                out_muted_ff;
   logic                out_last_ff;
   logic [SW-1:0]       last_sample_ff;
   logic [SW-1:0]       sample_sel;

   assign a_adv = a_valid_ff && (!out_valid_ff || rsp_tready);
   assign pop   = q_valid && (!a_valid_ff || a_adv);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (pop) begin
         a_valid_in = !q_ctl.is_load;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (a_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (a_ctl_ff.hold_last) begin
         sample_sel = last_sample_ff;
      end else if (a_ctl_ff.use_table) begin
         sample_sel = rd_ff;
      end else begin
         sample_sel = a_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && q_ctl.is_load) begin
         wave_mem[q_addr] <= q_data;
      end
      if (pop && !q_ctl.is_load) begin
         rd_ff <= wave_mem[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
         last_sample_ff <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         if (a_adv && !a_ctl_ff.hold_last) begin
            last_sample_ff <= sample_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_ctl_ff <= q_ctl;
         a_sq_ff  <= q_data;
      end
      if (a_adv) begin
         out_sample_ff <= sample_sel;
         out_muted_ff  <= a_ctl_ff.hold_last;
         out_last_ff   <= a_ctl_ff.tone_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_muted_ff;
   assign rsp_tlast  = out_last_ff;

   `ASSERT_NEVER(a_muted_not_last, clock, reset, rsp_tvalid && rsp_tuser && rsp_tlast,
      "muted sample flagged as last of a tone")
   `ASSERT_NEVER(a_stage_load, clock, reset, a_valid_ff && a_ctl_ff.is_load,
      "table load reached the sample stage")

endmodule

// ===== sim/tb_wavetable_square_tone_generator.sv =====
`timescale 1ns / 100ps
// Self-checking bench for wavetable_square_tone_generator: table loads, tone
// starts and ticks go in on the request stream, and every sample is checked
// against a behavioral oscillator or a directed value. Depends on tsg_pkg and the generator RTL.
module tb_wavetable_square_tone_generator;

   localparam logic [tsg_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RUN_ITEMS    = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int DEPTH        = tsg_pkg::TABLE_DEPTH_DEFAULT;

   // request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [tsg_pkg::ACC_W-1:0]    samples;
      logic [tsg_pkg::HALF_W-1:0]   half;
      logic [tsg_pkg::ACC_W-1:0]    step;
      logic [tsg_pkg::SAMPLE_W-1:0] value;
      logic [tsg_pkg::INDEX_W-1:0]  index;
   } req_fields_type;

   typedef struct packed {
      logic [tsg_pkg::SAMPLE_W-1:0] level;
      logic                         muted;
      logic                         last;
   } sample_type;

   typedef struct {
      bit                         is_csr;
      logic [tsg_pkg::REQ_W-1:0]  kind;
      req_fields_type             f;
      bit                         typed;
      sample_type                 exp;
      logic                       mode;
      logic [tsg_pkg::AMP_W-1:0]  amp;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [87:0]                   req_tdata = '0;
   logic [tsg_pkg::REQ_W-1:0]     req_tuser = tsg_pkg::REQ_TICK;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tsg_pkg::SAMPLE_W-1:0]  rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [tsg_pkg::CSR_AW-1:0]    csr_addr = tsg_pkg::CSR_WAVE_MODE;
   logic [tsg_pkg::AMP_W-1:0]     csr_wdata = '0;

   wavetable_square_tone_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // oscillator state as the block should hold it
   logic [tsg_pkg::SAMPLE_W-1:0] osc_table [DEPTH];
   bit                           osc_written [DEPTH];
   logic [tsg_pkg::ACC_W-1:0]    osc_phase = '0;
   logic [tsg_pkg::ACC_W-1:0]    osc_step = '0;
   logic [tsg_pkg::ACC_W-1:0]    osc_left = '0;
   int                           osc_half_len = 1;
   int                           osc_half_cnt = 0;
   logic [tsg_pkg::SAMPLE_W-1:0] osc_level = '0;
   logic [tsg_pkg::SAMPLE_W-1:0] osc_last = '0;
   logic                         osc_mode = 1'b0;
   logic [tsg_pkg::AMP_W-1:0]    osc_amp = tsg_pkg::AMP_RESET;

   sample_type pending_samples [$];
   int         mismatch_count = 0;
   int         checked_samples = 0;
   int         sent_items = 0;
   int         cycle_count = 0;
   int         burst_left = 0;
   int         stall_mode = 0;
   row_type    directed_rows [$];

   task automatic predict_sample(input logic [tsg_pkg::REQ_W-1:0] kind,
                                 input req_fields_type f,
                                 output bit produces, output sample_type s);
      int pos;
      logic [tsg_pkg::SAMPLE_W-1:0] table_word;
      produces = 1'b0;
      s = '0;
      case (kind)
         tsg_pkg::REQ_LOAD: begin
            osc_table[f.index] = f.value;
            osc_written[f.index] = 1'b1;
         end
         tsg_pkg::REQ_START: begin
            osc_step = f.step;
            osc_half_len = (f.half == 0) ? 1 : int'(f.half);
            osc_left = f.samples;
            osc_phase = '0;
            osc_half_cnt = 0;
            osc_level = tsg_pkg::SAMPLE_W'(osc_amp);
         end
         tsg_pkg::REQ_TICK: begin
            produces = 1'b1;
            if (osc_left == 0) begin
               s = '{level: osc_last, muted: 1'b1, last: 1'b0};
            end else begin
               pos = int'(osc_phase >> tsg_pkg::PHASE_FRAC_DEFAULT) % DEPTH;
               table_word = osc_table[pos];
               osc_phase = osc_phase + osc_step;
               // both generators advance; the mode only picks the output
               if (osc_half_cnt == 0) osc_level = -osc_level;
               osc_half_cnt++;
               if (osc_half_cnt >= osc_half_len) osc_half_cnt = 0;
               s.level = osc_mode ? osc_level : table_word;
               s.muted = 1'b0;
               s.last = (osc_left == 1);
               osc_last = s.level;
               osc_left--;
            end
         end
         default: ;
      endcase
   endtask

   function automatic req_fields_type random_fields();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[87:0];
   endfunction

   function automatic row_type item_row(logic [tsg_pkg::REQ_W-1:0] kind,
                                        logic [tsg_pkg::INDEX_W-1:0] index,
                                        logic [tsg_pkg::SAMPLE_W-1:0] value,
                                        logic [tsg_pkg::ACC_W-1:0] step,
                                        logic [tsg_pkg::HALF_W-1:0] half,
                                        logic [tsg_pkg::ACC_W-1:0] samples);
      row_type r;
      r = '{default: '0};
      r.kind = kind;
      r.f = '{samples: samples, half: half, step: step, value: value, index: index};
      return r;
   endfunction

   function automatic row_type tick_row(bit typed, logic [tsg_pkg::SAMPLE_W-1:0] level,
                                        logic muted, logic last);
      row_type r;
      r = '{default: '0};
      r.kind = tsg_pkg::REQ_TICK;
      r.typed = typed;
      r.exp = '{level: level, muted: muted, last: last};
      return r;
   endfunction

   function automatic row_type csr_row(logic mode, logic [tsg_pkg::AMP_W-1:0] amp);
      row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.mode = mode;
      r.amp = amp;
      return r;
   endfunction

   task automatic send_request(input logic [tsg_pkg::REQ_W-1:0] kind,
                               input req_fields_type f,
                               input bit typed, input sample_type typed_exp);
      int gap;
      bit produces;
      sample_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sample(kind, f, produces, predicted);
      if (produces) pending_samples.push_back(typed ? typed_exp : predicted);
      if (kind != REQ_UNUSED) sent_items++;
   endtask

   // write both registers once the pipeline has drained
   task automatic write_regs(input logic mode, input logic [tsg_pkg::AMP_W-1:0] amp);
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= tsg_pkg::CSR_WAVE_MODE;
      csr_wdata <= tsg_pkg::AMP_W'(mode);
      @(posedge clock);
      csr_addr <= tsg_pkg::CSR_SQUARE_AMP;
      csr_wdata <= amp;
      @(posedge clock);
      csr_we <= 1'b0;
      osc_mode = mode;
      osc_amp = amp;
   endtask

   task automatic load_random_entry();
      send_request(tsg_pkg::REQ_LOAD, random_fields(), 1'b0, '0);
   endtask

   // a tick that would read an entry never written gets that entry loaded first
   task automatic tick_tone();
      req_fields_type f;
      int pos;
      pos = int'(osc_phase >> tsg_pkg::PHASE_FRAC_DEFAULT) % DEPTH;
      if (osc_left != 0 && !osc_written[pos]) begin
         f = random_fields();
         f.index = tsg_pkg::INDEX_W'(pos);
         send_request(tsg_pkg::REQ_LOAD, f, 1'b0, '0);
      end
      send_request(tsg_pkg::REQ_TICK, random_fields(), 1'b0, '0);
   endtask

   task automatic start_random_tone(output int ticks);
      req_fields_type f;
      f = random_fields();
      case ($urandom_range(0, 3))
         0: f.step = tsg_pkg::ACC_W'($urandom_range(0, 'h30000));
         1: f.step = tsg_pkg::ACC_W'($urandom_range(0, 3)) << tsg_pkg::PHASE_FRAC_DEFAULT;
         2: ;
         default: f.step = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
      case ($urandom_range(0, 9))
         0, 1: f.half = '0;
         2: ;
         default: f.half = tsg_pkg::HALF_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 19))
         0, 1: f.samples = '0;
         2: ;
         default: f.samples = tsg_pkg::ACC_W'($urandom_range(1, 40));
      endcase
      // long tones are cut short by the next start
      ticks = ((f.samples > 48) ? 48 : int'(f.samples)) + $urandom_range(0, 3);
      send_request(tsg_pkg::REQ_START, f, 1'b0, '0);
   endtask

   task automatic run_random_phase();
      int tones;
      int ticks;
      int restart_ticks;
      logic [tsg_pkg::AMP_W-1:0] amp;
      case ($urandom_range(0, 3))
         0: amp = '0;
         1: amp = '1;
         2: amp = tsg_pkg::AMP_RESET;
         default: amp = tsg_pkg::AMP_W'($urandom);
      endcase
      write_regs(1'($urandom_range(0, 1)), amp);
      tones = $urandom_range(2, 6);
      repeat (tones) begin
         repeat ($urandom_range(0, 3)) load_random_entry();
         start_random_tone(ticks);
         repeat (ticks) begin
            case ($urandom_range(0, 39))
               0, 1: load_random_entry();
               2: send_request(REQ_UNUSED, random_fields(), 1'b0, '0);
               3: start_random_tone(restart_ticks);
               default: ;
            endcase
            tick_tone();
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d samples still outstanding", $time,
                  pending_samples.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: compare each transfer, then pick the next ready value
   always @(posedge clock) begin : check_results
      sample_type got;
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{level: rsp_tdata, muted: rsp_tuser, last: rsp_tlast};
         if (pending_samples.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected sample %0d muted %0b last %0b", $time,
                     $signed(got.level), got.muted, got.last);
         end else begin
            want = pending_samples.pop_front();
            checked_samples++;
            if (got.level !== want.level || got.muted !== want.muted ||
                got.last !== want.last) begin
               mismatch_count++;
               $display("%0t: expected sample %0d muted %0b last %0b, got %0d muted %0b last %0b",
                        $time, $signed(want.level), want.muted, want.last,
                        $signed(got.level), got.muted, got.last);
            end
         end
      end
      if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         2: rsp_tready <= (cycle_count % 7) > 1;
         default: rsp_tready <= (cycle_count % 32) >= 20;
      endcase
   end

   initial begin : stimulus
      row_type r;
      // after reset: muted, last sample zero
      directed_rows.push_back(tick_row(1'b1, 16'h0000, 1'b1, 1'b0));
      directed_rows.push_back(item_row(REQ_UNUSED, '1, '1, '1, '1, '1));
      directed_rows.push_back(item_row(tsg_pkg::REQ_LOAD, 8'd0, 16'h7FFF, '0, '0, '0));
      directed_rows.push_back(item_row(tsg_pkg::REQ_LOAD, 8'd255, 16'h8000, '0, '0, '0));
      // step of 255 positions walks entry 0 then entry 255
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, 24'hFF0000, 16'd0,
                                       24'd2));
      directed_rows.push_back(tick_row(1'b1, 16'h7FFF, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b1, 16'h8000, 1'b0, 1'b1));
      directed_rows.push_back(tick_row(1'b1, 16'h8000, 1'b1, 1'b0));
      // zero length tone stays idle
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, 24'h001234, 16'd7,
                                       24'd0));
      directed_rows.push_back(tick_row(1'b1, 16'h8000, 1'b1, 1'b0));
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, '1, '1, 24'd2));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      // square, full amplitude, zero half period inverts every sample
      directed_rows.push_back(csr_row(1'b1, '1));
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, '0, 16'd0, 24'd3));
      directed_rows.push_back(tick_row(1'b1, 16'h8001, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b1, 16'h7FFF, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b1, 16'h8001, 1'b0, 1'b1));
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, '0, '1, '1));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      // restart in the middle of a tone
      directed_rows.push_back(item_row(tsg_pkg::REQ_START, '0, '0, '0, 16'd1, 24'd1));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(tick_row(1'b0, '0, 1'b0, 1'b0));
      directed_rows.push_back(csr_row(1'b0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.is_csr) write_regs(r.mode, r.amp);
         else send_request(r.kind, r.f, r.typed, r.exp);
      end

      while (sent_items < RUN_ITEMS) run_random_phase();

      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d requests (loads, starts, ticks) over sine and square settings,",
               sent_items);
      $display("checked %0d samples, %0d mismatches", checked_samples, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/tsg_pkg.sv
src/tsg_queue.sv
src/tsg_front.sv
src/tsg_back.sv
src/wavetable_square_tone_generator.sv
sim/tb_wavetable_square_tone_generator.sv
